// File: hw/rtl/triangle_circumcircle_incircle_unit_macros.svh
// assertion macros for the circumcircle unit
`ifndef TRIANGLE_CIRCUMCIRCLE_INCIRCLE_UNIT_MACROS_SVH
`define TRIANGLE_CIRCUMCIRCLE_INCIRCLE_UNIT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define TCC_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// condition never holds
`define TCC_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

// File: hw/rtl/tcc_pkg.sv
// shared constants for the circumcircle unit
`timescale 1ns / 1ps
package tcc_pkg;

  localparam int OUT_W = 32;
  localparam int ROOT_W = 33;
  localparam int MIN_QUOT_W = 34;
  localparam logic signed [OUT_W-1:0] CENTRE_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [OUT_W-1:0] CENTRE_MIN = 32'sh8000_0000;

endpackage

// File: hw/rtl/tcc_in_if.sv
// request channel carrying triangle vertices and query point
`timescale 1ns / 1ps
interface tcc_in_if #(
  parameter int CoordBits = 16
) ();
  logic                        valid;
  logic                        ready;
  logic signed [CoordBits-1:0] vertex_a_x;
  logic signed [CoordBits-1:0] vertex_a_y;
  logic signed [CoordBits-1:0] vertex_b_x;
  logic signed [CoordBits-1:0] vertex_b_y;
  logic signed [CoordBits-1:0] vertex_c_x;
  logic signed [CoordBits-1:0] vertex_c_y;
  logic signed [CoordBits-1:0] query_x;
  logic signed [CoordBits-1:0] query_y;

  modport source (
    output valid, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
           vertex_c_x, vertex_c_y, query_x, query_y,
    input  ready
  );
  modport sink (
    input  valid, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
           vertex_c_x, vertex_c_y, query_x, query_y,
    output ready
  );
endinterface

// File: hw/rtl/tcc_out_if.sv
// result channel carrying centre, radius and flags
`timescale 1ns / 1ps
interface tcc_out_if import tcc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] centre_x;
  logic signed [OUT_W-1:0] centre_y;
  logic [OUT_W-1:0]        circle_radius;
  logic                    inside_res;
  logic                    degenerate;
  logic                    saturated;

  modport source (
    output valid, centre_x, centre_y, circle_radius, inside_res, degenerate, saturated,
    input  ready
  );
  modport sink (
    input  valid, centre_x, centre_y, circle_radius, inside_res, degenerate, saturated,
    output ready
  );
endinterface

// File: hw/rtl/tcc_divider.sv
// pipelined two-lane restoring divider, one quotient bit per stage, saturating
`timescale 1ns / 1ps
module tcc_divider import tcc_pkg::*; #(
  parameter int NUM_W  = 64,
  parameter int DEN_W  = 35,
  parameter int QB     = 34,
  parameter int SIDE_W = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [1:0][NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]       den_i,
  input  logic [1:0]             neg_i,
  input  logic [SIDE_W-1:0]      side_i,
  output logic                   valid_o,
  output logic [1:0][QB-1:0]     quot_o,
  output logic [1:0]             neg_o,
  output logic [SIDE_W-1:0]      side_o
);

  localparam int NE   = (NUM_W > QB) ? NUM_W : QB + 1;
  localparam int HI_W = NE - QB;
  localparam int CW   = (HI_W > DEN_W) ? HI_W : DEN_W;

  logic              valid_q [QB+1];
  logic [DEN_W-1:0]  den_q   [QB+1];
  logic [SIDE_W-1:0] side_q  [QB+1];
  logic [1:0]        neg_q   [QB+1];
  logic [1:0]        ovf_q   [QB+1];
  logic [DEN_W-1:0]  rem_q   [2][QB+1];
  logic [QB-1:0]     low_q   [2][QB+1];
  logic [QB-1:0]     quo_q   [2][QB+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else if (en_i) begin
      valid_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q[0]  <= den_i;
      side_q[0] <= side_i;
      neg_q[0]  <= neg_i;
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [NE-1:0] num_ext;
    logic [CW-1:0] hi;
    logic          ovf;

    assign num_ext = NE'(num_i[l]);
    assign hi      = CW'(num_ext[NE-1:QB]);
    assign ovf     = hi >= CW'(den_i);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ovf_q[0][l]  <= ovf;
        rem_q[l][0]  <= ovf ? '0 : DEN_W'(hi);
        low_q[l][0]  <= num_ext[QB-1:0];
        quo_q[l][0]  <= '0;
      end
    end

    for (genvar k = 1; k <= QB; k++) begin : g_step
      logic [DEN_W:0] trial;
      logic           ge;

      assign trial = {rem_q[l][k-1], low_q[l][k-1][QB-k]};
      assign ge    = trial >= {1'b0, den_q[k-1]};

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[l][k] <= ge ? DEN_W'(trial - {1'b0, den_q[k-1]}) : DEN_W'(trial);
          low_q[l][k] <= low_q[l][k-1];
          quo_q[l][k] <= quo_q[l][k-1] | (QB'(ge) << (QB - k));
          ovf_q[k][l] <= ovf_q[k-1][l];
        end
      end
    end

    assign quot_o[l] = ovf_q[QB][l] ? '1 : quo_q[l][QB];
  end

  for (genvar k = 1; k <= QB; k++) begin : g_ctl
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= valid_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[k]  <= den_q[k-1];
        side_q[k] <= side_q[k-1];
        neg_q[k]  <= neg_q[k-1];
      end
    end
  end

  assign valid_o = valid_q[QB];
  assign neg_o   = neg_q[QB];
  assign side_o  = side_q[QB];

endmodule

// File: hw/rtl/tcc_isqrt.sv
// pipelined integer square root, one root bit per stage
`timescale 1ns / 1ps
module tcc_isqrt import tcc_pkg::*; #(
  parameter int RW     = ROOT_W,
  parameter int SIDE_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [2*RW-1:0]   rad_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [RW-1:0]     root_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int REM_W = RW + 3;

  logic              valid_q [RW+1];
  logic [2*RW-1:0]   rad_q   [RW+1];
  logic [REM_W-1:0]  rem_q   [RW+1];
  logic [RW-1:0]     root_q  [RW+1];
  logic [SIDE_W-1:0] side_q  [RW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else if (en_i) begin
      valid_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q[0]  <= rad_i;
      rem_q[0]  <= '0;
      root_q[0] <= '0;
      side_q[0] <= side_i;
    end
  end

  for (genvar k = 1; k <= RW; k++) begin : g_step
    logic [REM_W-1:0] cur;
    logic [REM_W-1:0] trial;
    logic             ge;

    assign cur   = {rem_q[k-1][REM_W-3:0], rad_q[k-1][2*(RW-k)+1 -: 2]};
    assign trial = REM_W'({root_q[k-1], 2'b01});
    assign ge    = cur >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= valid_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? cur - trial : cur;
        root_q[k] <= {root_q[k-1][RW-2:0], ge};
        rad_q[k]  <= rad_q[k-1];
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign valid_o = valid_q[RW];
  assign root_o  = root_q[RW];
  assign side_o  = side_q[RW];

endmodule

// File: hw/rtl/triangle_circumcircle_incircle_unit.sv
// circumcircle centre, radius and in-circle test, fully pipelined
//
//   port   dir  carries
//   in_i   in   vertices a, b, c and query point, signed integers
//   out_o  out  centre (q.8), radius (q.8), inside, degenerate, saturated
//
// one request per cycle unless the output stalls; divider and square root are bit-per-stage.
// all stages advance together while the output register is empty or being taken.
// a stall at the output freezes every stage; nothing is dropped or repeated.
// reset clears only the valid bits.
`timescale 1ns / 1ps
`include "triangle_circumcircle_incircle_unit_macros.svh"
module triangle_circumcircle_incircle_unit import tcc_pkg::*; #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tcc_in_if.sink    in_i,
  tcc_out_if.source out_o
);

  localparam int C      = COORD_BITS;
  localparam int DIFF_W = C + 1;
  localparam int PROD_W = 2 * C + 2;
  localparam int S_W    = 2 * C + 3;
  localparam int D_W    = 2 * C + 3;
  localparam int NP_W   = 3 * C + 4;
  localparam int N_W    = 3 * C + 5;
  localparam int LR_W   = 4 * C + 7;
  localparam int NUM_W  = N_W + FRAC_BITS;
  localparam int QB     = (MIN_QUOT_W > C + FRAC_BITS + 2) ? MIN_QUOT_W : C + FRAC_BITS + 2;
  localparam int OX_W   = QB + 1;
  localparam int CEN_W  = ((OX_W > C + FRAC_BITS) ? OX_W : C + FRAC_BITS) + 1;
  localparam int DSIDE_W = 2 * C + 2;
  localparam int QSIDE_W = 2 * OUT_W + 4;

  logic en;
  assign en = !out_o.valid || out_o.ready;
  assign in_i.ready = en;

  // stage 1: offsets from vertex a
  logic                     v1_q;
  logic signed [C-1:0]      ax1_q, ay1_q;
  logic signed [DIFF_W-1:0] a1_1_q, b1_1_q, a2_1_q, b2_1_q, ux1_q, uy1_q;

  // stage 2: products
  logic                     v2_q;
  logic signed [C-1:0]      ax2_q, ay2_q;
  logic signed [DIFF_W-1:0] a1_2_q, b1_2_q, a2_2_q, b2_2_q, ux2_q, uy2_q;
  logic signed [PROD_W-1:0] pa1b2_q, pa2b1_q, pa1a1_q, pb1b1_q, pa2a2_q, pb2b2_q;
  logic signed [PROD_W-1:0] puxux_q, puyuy_q;

  // stage 3: determinant and squared lengths
  logic                     v3_q;
  logic signed [C-1:0]      ax3_q, ay3_q;
  logic signed [DIFF_W-1:0] a1_3_q, b1_3_q, a2_3_q, b2_3_q, ux3_q, uy3_q;
  logic signed [D_W-1:0]    d3_q;
  logic signed [S_W-1:0]    s1_q, s2_q, uq_q;

  // stage 4: numerator products
  logic                     v4_q;
  logic signed [C-1:0]      ax4_q, ay4_q;
  logic signed [DIFF_W-1:0] ux4_q, uy4_q;
  logic signed [D_W-1:0]    d4_q;
  logic                     deg4_q;
  logic signed [NP_W-1:0]   ms1b2_q, ms2b1_q, ma1s2_q, ma2s1_q;
  logic signed [LR_W-1:0]   lhs4_q;

  // stage 5: numerators
  logic                     v5_q;
  logic signed [C-1:0]      ax5_q, ay5_q;
  logic signed [DIFF_W-1:0] ux5_q, uy5_q;
  logic signed [D_W-1:0]    d5_q;
  logic                     deg5_q;
  logic signed [N_W-1:0]    nx5_q, ny5_q;
  logic signed [LR_W-1:0]   lhs5_q;

  // stage 6: in-circle products, divider operands
  logic                     v6_q;
  logic signed [C-1:0]      ax6_q, ay6_q;
  logic                     deg6_q, dneg6_q;
  logic signed [LR_W-1:0]   lhs6_q, rx6_q, ry6_q;
  logic [1:0][NUM_W-1:0]    num6_q;
  logic [1:0]               neg6_q;
  logic [D_W-1:0]           den6_q;

  // stage 7: in-circle compare
  logic                     v7_q;
  logic signed [C-1:0]      ax7_q, ay7_q;
  logic                     deg7_q, in7_q;
  logic [1:0][NUM_W-1:0]    num7_q;
  logic [1:0]               neg7_q;
  logic [D_W-1:0]           den7_q;

  logic [N_W-1:0]           nx_mag, ny_mag;
  logic [D_W-1:0]           d_mag;
  logic signed [LR_W-1:0]   rhs6;

  assign nx_mag = nx5_q[N_W-1] ? N_W'(-nx5_q) : N_W'(nx5_q);
  assign ny_mag = ny5_q[N_W-1] ? N_W'(-ny5_q) : N_W'(ny5_q);
  assign d_mag  = d5_q[D_W-1] ? D_W'(-d5_q) : D_W'(d5_q);
  assign rhs6   = rx6_q + ry6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax1_q  <= in_i.vertex_a_x;
      ay1_q  <= in_i.vertex_a_y;
      a1_1_q <= DIFF_W'(in_i.vertex_b_x) - DIFF_W'(in_i.vertex_a_x);
      b1_1_q <= DIFF_W'(in_i.vertex_b_y) - DIFF_W'(in_i.vertex_a_y);
      a2_1_q <= DIFF_W'(in_i.vertex_c_x) - DIFF_W'(in_i.vertex_a_x);
      b2_1_q <= DIFF_W'(in_i.vertex_c_y) - DIFF_W'(in_i.vertex_a_y);
      ux1_q  <= DIFF_W'(in_i.query_x) - DIFF_W'(in_i.vertex_a_x);
      uy1_q  <= DIFF_W'(in_i.query_y) - DIFF_W'(in_i.vertex_a_y);

      ax2_q   <= ax1_q;
      ay2_q   <= ay1_q;
      a1_2_q  <= a1_1_q;
      b1_2_q  <= b1_1_q;
      a2_2_q  <= a2_1_q;
      b2_2_q  <= b2_1_q;
      ux2_q   <= ux1_q;
      uy2_q   <= uy1_q;
      pa1b2_q <= PROD_W'(a1_1_q) * PROD_W'(b2_1_q);
      pa2b1_q <= PROD_W'(a2_1_q) * PROD_W'(b1_1_q);
      pa1a1_q <= PROD_W'(a1_1_q) * PROD_W'(a1_1_q);
      pb1b1_q <= PROD_W'(b1_1_q) * PROD_W'(b1_1_q);
      pa2a2_q <= PROD_W'(a2_1_q) * PROD_W'(a2_1_q);
      pb2b2_q <= PROD_W'(b2_1_q) * PROD_W'(b2_1_q);
      puxux_q <= PROD_W'(ux1_q) * PROD_W'(ux1_q);
      puyuy_q <= PROD_W'(uy1_q) * PROD_W'(uy1_q);

      ax3_q  <= ax2_q;
      ay3_q  <= ay2_q;
      a1_3_q <= a1_2_q;
      b1_3_q <= b1_2_q;
      a2_3_q <= a2_2_q;
      b2_3_q <= b2_2_q;
      ux3_q  <= ux2_q;
      uy3_q  <= uy2_q;
      d3_q   <= D_W'(pa1b2_q) - D_W'(pa2b1_q);
      s1_q   <= S_W'(pa1a1_q) + S_W'(pb1b1_q);
      s2_q   <= S_W'(pa2a2_q) + S_W'(pb2b2_q);
      uq_q   <= S_W'(puxux_q) + S_W'(puyuy_q);

      ax4_q   <= ax3_q;
      ay4_q   <= ay3_q;
      ux4_q   <= ux3_q;
      uy4_q   <= uy3_q;
      d4_q    <= d3_q;
      deg4_q  <= d3_q == '0;
      ms1b2_q <= NP_W'(s1_q) * NP_W'(b2_3_q);
      ms2b1_q <= NP_W'(s2_q) * NP_W'(b1_3_q);
      ma1s2_q <= NP_W'(a1_3_q) * NP_W'(s2_q);
      ma2s1_q <= NP_W'(a2_3_q) * NP_W'(s1_q);
      lhs4_q  <= LR_W'(uq_q) * LR_W'(d3_q);

      ax5_q  <= ax4_q;
      ay5_q  <= ay4_q;
      ux5_q  <= ux4_q;
      uy5_q  <= uy4_q;
      d5_q   <= d4_q;
      deg5_q <= deg4_q;
      nx5_q  <= N_W'(ms1b2_q) - N_W'(ms2b1_q);
      ny5_q  <= N_W'(ma1s2_q) - N_W'(ma2s1_q);
      lhs5_q <= lhs4_q;

      ax6_q     <= ax5_q;
      ay6_q     <= ay5_q;
      deg6_q    <= deg5_q;
      dneg6_q   <= d5_q[D_W-1];
      lhs6_q    <= lhs5_q;
      rx6_q     <= LR_W'(ux5_q) * LR_W'(nx5_q);
      ry6_q     <= LR_W'(uy5_q) * LR_W'(ny5_q);
      num6_q[0] <= NUM_W'(nx_mag) << FRAC_BITS;
      num6_q[1] <= NUM_W'(ny_mag) << FRAC_BITS;
      neg6_q[0] <= nx5_q[N_W-1] ^ d5_q[D_W-1];
      neg6_q[1] <= ny5_q[N_W-1] ^ d5_q[D_W-1];
      den6_q    <= D_W'(d_mag << 1);

      ax7_q  <= ax6_q;
      ay7_q  <= ay6_q;
      deg7_q <= deg6_q;
      in7_q  <= dneg6_q ? (lhs6_q >= rhs6) : (lhs6_q <= rhs6);
      num7_q <= num6_q;
      neg7_q <= neg6_q;
      den7_q <= den6_q;
    end
  end

  // division of both numerators by 2d
  logic                  dv_valid;
  logic [1:0][QB-1:0]    dv_quot;
  logic [1:0]            dv_neg;
  logic [DSIDE_W-1:0]    dv_side;

  tcc_divider #(
    .NUM_W  (NUM_W),
    .DEN_W  (D_W),
    .QB     (QB),
    .SIDE_W (DSIDE_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v7_q),
    .num_i   (num7_q),
    .den_i   (den7_q),
    .neg_i   (neg7_q),
    .side_i  ({ax7_q, ay7_q, in7_q, deg7_q}),
    .valid_o (dv_valid),
    .quot_o  (dv_quot),
    .neg_o   (dv_neg),
    .side_o  (dv_side)
  );

  // stage after divide: centre with clipping, squared offsets
  logic signed [C-1:0]     dv_ax, dv_ay;
  logic                    dv_in, dv_deg;
  logic signed [OX_W-1:0]  ox, oy;
  logic signed [CEN_W-1:0] cx, cy;
  logic signed [OUT_W-1:0] cx_clip, cy_clip;
  logic                    cx_sat, cy_sat;

  assign {dv_ax, dv_ay, dv_in, dv_deg} = dv_side;
  assign ox = dv_neg[0] ? -OX_W'(dv_quot[0]) : OX_W'(dv_quot[0]);
  assign oy = dv_neg[1] ? -OX_W'(dv_quot[1]) : OX_W'(dv_quot[1]);
  assign cx = CEN_W'(ox) + (CEN_W'(dv_ax) <<< FRAC_BITS);
  assign cy = CEN_W'(oy) + (CEN_W'(dv_ay) <<< FRAC_BITS);

  always_comb begin
    cx_sat  = 1'b1;
    cx_clip = CENTRE_MAX;
    if (cx > CEN_W'(CENTRE_MAX)) begin
      cx_clip = CENTRE_MAX;
    end else if (cx < CEN_W'(CENTRE_MIN)) begin
      cx_clip = CENTRE_MIN;
    end else begin
      cx_sat  = 1'b0;
      cx_clip = OUT_W'(cx);
    end
    cy_sat  = 1'b1;
    cy_clip = CENTRE_MAX;
    if (cy > CEN_W'(CENTRE_MAX)) begin
      cy_clip = CENTRE_MAX;
    end else if (cy < CEN_W'(CENTRE_MIN)) begin
      cy_clip = CENTRE_MIN;
    end else begin
      cy_sat  = 1'b0;
      cy_clip = OUT_W'(cy);
    end
  end

  logic                    v8_q;
  logic signed [OUT_W-1:0] cx8_q, cy8_q;
  logic                    csat8_q, big8_q, in8_q, deg8_q;
  logic [2*OUT_W-1:0]      sqx8_q, sqy8_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v8_q <= 1'b0;
    end else if (en) begin
      v8_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cx8_q   <= cx_clip;
      cy8_q   <= cy_clip;
      csat8_q <= cx_sat || cy_sat;
      big8_q  <= (|dv_quot[0][QB-1:OUT_W]) || (|dv_quot[1][QB-1:OUT_W]);
      in8_q   <= dv_in;
      deg8_q  <= dv_deg;
      sqx8_q  <= (2*OUT_W)'(dv_quot[0][OUT_W-1:0]) * (2*OUT_W)'(dv_quot[0][OUT_W-1:0]);
      sqy8_q  <= (2*OUT_W)'(dv_quot[1][OUT_W-1:0]) * (2*OUT_W)'(dv_quot[1][OUT_W-1:0]);
    end
  end

  // radius square root
  logic                  sq_valid;
  logic [ROOT_W-1:0]     sq_root;
  logic [QSIDE_W-1:0]    sq_side;
  logic signed [OUT_W-1:0] sq_cx, sq_cy;
  logic                  sq_csat, sq_big, sq_in, sq_deg;
  logic                  rad_sat;

  tcc_isqrt #(
    .RW     (ROOT_W),
    .SIDE_W (QSIDE_W)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v8_q),
    .rad_i   ((2*ROOT_W)'(sqx8_q) + (2*ROOT_W)'(sqy8_q)),
    .side_i  ({cx8_q, cy8_q, csat8_q, big8_q, in8_q, deg8_q}),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  assign {sq_cx, sq_cy, sq_csat, sq_big, sq_in, sq_deg} = sq_side;
  assign rad_sat = sq_big || sq_root[ROOT_W-1];

  // output register
  logic                    out_valid_q;
  logic signed [OUT_W-1:0] out_cx_q, out_cy_q;
  logic [OUT_W-1:0]        out_rad_q;
  logic                    out_in_q, out_deg_q, out_sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= sq_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (sq_deg) begin
        out_cx_q  <= '0;
        out_cy_q  <= '0;
        out_rad_q <= '0;
        out_in_q  <= 1'b0;
        out_deg_q <= 1'b1;
        out_sat_q <= 1'b0;
      end else begin
        out_cx_q  <= sq_cx;
        out_cy_q  <= sq_cy;
        out_rad_q <= rad_sat ? '1 : sq_root[OUT_W-1:0];
        out_in_q  <= sq_in;
        out_deg_q <= 1'b0;
        out_sat_q <= sq_csat || rad_sat;
      end
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.centre_x      = out_cx_q;
  assign out_o.centre_y      = out_cy_q;
  assign out_o.circle_radius = out_rad_q;
  assign out_o.inside_res    = out_in_q;
  assign out_o.degenerate    = out_deg_q;
  assign out_o.saturated     = out_sat_q;

  `TCC_ASSERT_IMPL(a_deg_zero, out_valid_q && out_deg_q, out_cx_q == '0 && out_cy_q == '0 && out_rad_q == '0 && !out_in_q && !out_sat_q, "degenerate result not cleared")
  `TCC_ASSERT_IMPL(a_sat_src, out_valid_q && out_sat_q && out_rad_q != '1, out_cx_q == CENTRE_MAX || out_cx_q == CENTRE_MIN || out_cy_q == CENTRE_MAX || out_cy_q == CENTRE_MIN, "saturation without a clipped value")
  `TCC_ASSERT_NEVER(a_idle_ready, !out_valid_q && !in_i.ready, "request refused with empty output")

endmodule

// File: tb/triangle_circumcircle_incircle_unit_tb.sv
// self-checking testbench for the circumcircle and in-circle unit
`timescale 1ns / 1ps
module triangle_circumcircle_incircle_unit_tb;
  import tcc_pkg::*;

  localparam int CoordW = 16;
  localparam int FracW = 8;
  localparam int RandItems = 2000;
  localparam int StallLimit = 5000;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [127:0] wide_t;

  typedef struct {
    coord_t ax, ay, bx, by, cx, cy, qx, qy;
  } tri_req_t;

  typedef struct {
    logic signed [OUT_W-1:0] centre_x;
    logic signed [OUT_W-1:0] centre_y;
    logic [OUT_W-1:0]        radius;
    logic                    in_circle;
    logic                    degenerate;
    logic                    saturated;
  } circle_res_t;

  typedef struct {
    tri_req_t    rq;
    bit          typed;
    circle_res_t res;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #6 clk_i = ~clk_i;

  tcc_in_if #(.CoordBits(CoordW)) u_in ();
  tcc_out_if u_out ();

  triangle_circumcircle_incircle_unit #(
    .COORD_BITS(CoordW),
    .FRAC_BITS (FracW)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (u_in),
    .out_o (u_out)
  );

  circle_res_t expected_circles[$];
  int          errors = 0;
  int          idle_cycles = 0;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;

  function automatic logic [63:0] floor_sqrt(logic [127:0] v);
    logic [63:0]  r;
    logic [63:0]  t;
    logic [127:0] sq;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      t = r | (64'd1 << i);
      sq = {64'd0, t} * {64'd0, t};
      if (sq <= v) r = t;
    end
    return r;
  endfunction

  function automatic logic signed [OUT_W-1:0] clip_centre(wide_t v, inout logic sat);
    wide_t hi, lo;
    hi = CENTRE_MAX;
    lo = CENTRE_MIN;
    if (v > hi) begin
      sat = 1'b1;
      return CENTRE_MAX;
    end
    if (v < lo) begin
      sat = 1'b1;
      return CENTRE_MIN;
    end
    return v[OUT_W-1:0];
  endfunction

  function automatic circle_res_t predict_circle(tri_req_t rq);
    circle_res_t res;
    wide_t ax, ay, a1, b1, a2, b2, ux, uy, d, s1, s2, nx, ny, den, ox, oy;
    wide_t lhs, rhs, lim;
    logic [63:0] root;
    logic sat;
    ax = wide_t'(rq.ax); ay = wide_t'(rq.ay);
    a1 = wide_t'(rq.bx) - ax; b1 = wide_t'(rq.by) - ay;
    a2 = wide_t'(rq.cx) - ax; b2 = wide_t'(rq.cy) - ay;
    ux = wide_t'(rq.qx) - ax; uy = wide_t'(rq.qy) - ay;
    d = a1 * b2 - a2 * b1;
    res = '{default: '0};
    if (d == 0) begin
      res.degenerate = 1'b1;
      return res;
    end
    sat = 1'b0;
    s1 = a1 * a1 + b1 * b1;
    s2 = a2 * a2 + b2 * b2;
    nx = s1 * b2 - s2 * b1;
    ny = a1 * s2 - a2 * s1;
    den = 2 * d;
    ox = (nx <<< FracW) / den;
    oy = (ny <<< FracW) / den;
    res.centre_x = clip_centre((ax <<< FracW) + ox, sat);
    res.centre_y = clip_centre((ay <<< FracW) + oy, sat);
    lim = wide_t'(1) <<< 32;
    if (ox >= lim || -ox >= lim || oy >= lim || -oy >= lim) begin
      sat = 1'b1;
      res.radius = '1;
    end else begin
      root = floor_sqrt(ox * ox + oy * oy);
      if (root > 64'hFFFF_FFFF) begin
        sat = 1'b1;
        res.radius = '1;
      end else begin
        res.radius = root[OUT_W-1:0];
      end
    end
    lhs = (ux * ux + uy * uy) * d;
    rhs = ux * nx + uy * ny;
    res.in_circle = (d > 0) ? (lhs <= rhs) : (lhs >= rhs);
    res.saturated = sat;
    return res;
  endfunction

  function automatic tri_req_t mk(int ax, int ay, int bx, int by, int cx, int cy,
                                  int qx, int qy);
    tri_req_t rq;
    rq.ax = coord_t'(ax); rq.ay = coord_t'(ay); rq.bx = coord_t'(bx); rq.by = coord_t'(by);
    rq.cx = coord_t'(cx); rq.cy = coord_t'(cy); rq.qx = coord_t'(qx); rq.qy = coord_t'(qy);
    return rq;
  endfunction

  function automatic circle_res_t mk_res(int cx, int cy, int r, bit ins, bit deg, bit sat);
    circle_res_t res;
    res.centre_x = cx; res.centre_y = cy; res.radius = r;
    res.in_circle = ins; res.degenerate = deg; res.saturated = sat;
    return res;
  endfunction

  function automatic coord_t rnd_coord(int span);
    return coord_t'($urandom_range(2 * span) - span);
  endfunction

  function automatic tri_req_t random_triangle();
    tri_req_t rq;
    int kind, span, ox, oy, dx, dy, k;
    kind = $urandom_range(99);
    if (kind < 15) begin
      rq.ax = coord_t'($urandom); rq.ay = coord_t'($urandom);
      rq.bx = coord_t'($urandom); rq.by = coord_t'($urandom);
      rq.cx = coord_t'($urandom); rq.cy = coord_t'($urandom);
      rq.qx = coord_t'($urandom); rq.qy = coord_t'($urandom);
      return rq;
    end
    if (kind < 27) begin
      // collinear vertices
      dx = $urandom_range(200) - 100;
      dy = $urandom_range(200) - 100;
      k = $urandom_range(100) - 50;
      rq.ax = rnd_coord(16000); rq.ay = rnd_coord(16000);
      rq.bx = coord_t'(rq.ax + dx); rq.by = coord_t'(rq.ay + dy);
      rq.cx = coord_t'(rq.ax + k * dx); rq.cy = coord_t'(rq.ay + k * dy);
      rq.qx = coord_t'($urandom); rq.qy = coord_t'($urandom);
      return rq;
    end
    span = (kind < 40) ? 3 : (kind < 70) ? 300 : 12000;
    ox = $urandom_range(30000) - 15000;
    oy = $urandom_range(30000) - 15000;
    if (span > 1000) begin
      ox = 0;
      oy = 0;
    end
    rq.ax = coord_t'(ox + rnd_coord(span)); rq.ay = coord_t'(oy + rnd_coord(span));
    rq.bx = coord_t'(ox + rnd_coord(span)); rq.by = coord_t'(oy + rnd_coord(span));
    rq.cx = coord_t'(ox + rnd_coord(span)); rq.cy = coord_t'(oy + rnd_coord(span));
    rq.qx = coord_t'((rq.ax + rq.bx + rq.cx) / 3 + rnd_coord(span));
    rq.qy = coord_t'((rq.ay + rq.by + rq.cy) / 3 + rnd_coord(span));
    return rq;
  endfunction

  task automatic send_request(tri_req_t rq, bit typed, circle_res_t res);
    bit taken;
    while (!calm && $urandom_range(99) < 38) begin
      u_in.valid <= 1'b0;
      @(posedge clk_i);
    end
    u_in.valid <= 1'b1;
    u_in.vertex_a_x <= rq.ax; u_in.vertex_a_y <= rq.ay;
    u_in.vertex_b_x <= rq.bx; u_in.vertex_b_y <= rq.by;
    u_in.vertex_c_x <= rq.cx; u_in.vertex_c_y <= rq.cy;
    u_in.query_x <= rq.qx; u_in.query_y <= rq.qy;
    do begin
      @(negedge clk_i);
      taken = u_in.ready;
      if (taken) expected_circles.push_back(typed ? res : predict_circle(rq));
      @(posedge clk_i);
    end while (!taken);
  endtask

  task automatic check_field(string name, logic [OUT_W-1:0] exp_v, logic [OUT_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s expected %0h got %0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // result checking and stall watchdog
  always @(negedge clk_i) begin
    circle_res_t exp_r;
    if (rst_ni) begin
      if ((u_in.valid && u_in.ready) || (u_out.valid && u_out.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("triangle_circumcircle_incircle_unit_tb NOT OK");
        $finish;
      end
      if (u_out.valid && u_out.ready) begin
        if (expected_circles.size() == 0) begin
          $error("unexpected result");
          errors++;
        end else begin
          exp_r = expected_circles.pop_front();
          check_field("centre_x", exp_r.centre_x, u_out.centre_x);
          check_field("centre_y", exp_r.centre_y, u_out.centre_y);
          check_field("circle_radius", exp_r.radius, u_out.circle_radius);
          check_field("inside_res", OUT_W'(exp_r.in_circle), OUT_W'(u_out.inside_res));
          check_field("degenerate", OUT_W'(exp_r.degenerate), OUT_W'(u_out.degenerate));
          check_field("saturated", OUT_W'(exp_r.saturated), OUT_W'(u_out.saturated));
        end
      end
    end
  end

  // result side back-pressure
  initial begin
    int hold;
    hold = 0;
    u_out.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req && hold == 0) begin
        hold = 600;
        hold_req <= 1'b0;
      end
      if (hold > 0) begin
        hold--;
        u_out.ready <= 1'b0;
      end else begin
        u_out.ready <= calm || ($urandom_range(99) >= 38);
      end
    end
  end

  initial begin
    stim_row_t rows[$];
    circle_res_t none;
    int waited;
    none = '{default: '0};
    u_in.valid = 1'b0;
    u_in.vertex_a_x = '0; u_in.vertex_a_y = '0;
    u_in.vertex_b_x = '0; u_in.vertex_b_y = '0;
    u_in.vertex_c_x = '0; u_in.vertex_c_y = '0;
    u_in.query_x = '0; u_in.query_y = '0;

    rows.push_back('{mk(0, 0, 0, 0, 0, 0, 0, 0), 1, mk_res(0, 0, 0, 0, 1, 0)});
    rows.push_back('{mk(-32768, -32768, 32767, 32767, 0, 0, -32768, 32767), 1,
                     mk_res(0, 0, 0, 0, 1, 0)});
    rows.push_back('{mk(5, 5, 5, 5, 9, -3, 1, 1), 1, mk_res(0, 0, 0, 0, 1, 0)});
    rows.push_back('{mk(0, 0, 2, 0, 0, 2, 1, 1), 1, mk_res(256, 256, 362, 1, 0, 0)});
    rows.push_back('{mk(0, 0, 2, 0, 0, 2, 32767, 32767), 1, mk_res(256, 256, 362, 0, 0, 0)});
    rows.push_back('{mk(0, 0, 2, 0, 0, 2, 2, 2), 0, none});
    rows.push_back('{mk(0, 0, 0, 2, 2, 0, 0, 0), 0, none});
    rows.push_back('{mk(0, 0, 0, 2, 2, 0, -32768, -32768), 0, none});
    rows.push_back('{mk(-32768, -32768, 32767, -32768, -32768, 32767, 0, 0), 0, none});
    rows.push_back('{mk(32767, 32767, -32768, 32767, 32767, -32768, -1, -1), 0, none});
    rows.push_back('{mk(-32768, -32768, 32767, -32768, -32768, -32767, 0, 0), 0, none});
    rows.push_back('{mk(-32768, 0, 32767, 1, 0, 0, 32767, -32768), 0, none});
    rows.push_back('{mk(0, 0, 1, 0, 32767, 1, 100, 100), 0, none});
    rows.push_back('{mk(-1, -1, 1, -1, 0, 1, 0, 0), 0, none});
    rows.push_back('{mk(100, -200, -300, 50, 7, 900, 12, -40), 0, none});
    rows.push_back('{mk(1, 2, 3, 4, 5, 7, -32768, 32767), 0, none});

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_request(rows[i].rq, rows[i].typed, rows[i].res);

    for (int n = 0; n < RandItems; n++) begin
      if (n == 400) hold_req <= 1'b1;
      calm <= (n >= 1000 && n < 1300);
      if (n == 1500) begin
        u_in.valid <= 1'b0;
        @(posedge clk_i);
        while (expected_circles.size() != 0) @(posedge clk_i);
      end
      send_request(random_triangle(), 0, none);
    end
    u_in.valid <= 1'b0;

    while (expected_circles.size() != 0) @(posedge clk_i);
    waited = 0;
    while (waited < 120) begin
      @(posedge clk_i);
      waited++;
    end
    if (errors == 0 && expected_circles.size() == 0) begin
      $display("triangle_circumcircle_incircle_unit_tb OK");
    end else begin
      $display("triangle_circumcircle_incircle_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
